// File: rtl/pid_controller_trapezoid_integral_defines.svh
// pid_controller_trapezoid_integral_defines.svh
// assertion macros shared by the pidtrap_front, pidtrap_integ and pidtrap_out modules
// no dependencies
`ifndef PID_CONTROLLER_TRAPEZOID_INTEGRAL_DEFINES_SVH
`define PID_CONTROLLER_TRAPEZOID_INTEGRAL_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PID_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pid assertion failed");

// next-cycle implication, disabled while reset is low
`define PID_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pid assertion failed");

`endif

// File: rtl/pidtrap_pkg.sv
// pidtrap_pkg: widths, reset values, register indexes and the gain configuration struct
// used by every module of the pid block; no dependencies
`default_nettype none

package pidtrap_pkg;

    localparam int DEF_DATA_WIDTH = 16;
    localparam int DEF_FRAC_BITS  = 8;

    localparam int GAIN_W    = 16;
    localparam int LIMIT_W   = 15;
    localparam int BAND_W    = 16;
    localparam int ACC_BITS  = 40;
    localparam int REG_IDX_W = 3;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST = 16'd256;
    localparam logic [BAND_W-1:0] ZERO_BAND_RST = 16'd1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_INTEG_LIMIT = 3'd3,
        REG_OUT_MIN     = 3'd4,
        REG_OUT_MAX     = 3'd5,
        REG_ZERO_BAND   = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [LIMIT_W-1:0] integ_limit;
        logic [BAND_W-1:0]  zero_band;
    } t_gain_cfg;

endpackage

`default_nettype wire

// File: rtl/pidtrap_front.sv
// pidtrap_front: input register stage, forms the error and its trapezoid and derivative sums
// keeps the two previous errors; depends on pidtrap_pkg
`default_nettype none
`include "pid_controller_trapezoid_integral_defines.svh"

module pidtrap_front
    import pidtrap_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    localparam int ERR_W = DATA_WIDTH + 1,
    localparam int SUM_W = DATA_WIDTH + 2,
    localparam int DER_W = DATA_WIDTH + 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_setpoint,
    input  logic signed [DATA_WIDTH-1:0] i_measurement,
    input  logic                         i_clear,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [ERR_W-1:0]      o_err,
    output logic signed [SUM_W-1:0]      o_err_sum,
    output logic signed [DER_W-1:0]      o_err_der,
    output logic                         o_clear
);

    logic                    r_valid;
    logic signed [ERR_W-1:0] r_ep;
    logic signed [ERR_W-1:0] r_ep2;
    logic signed [ERR_W-1:0] r_err;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [DER_W-1:0] r_der;
    logic                    r_clear;

    logic                    load;
    logic signed [ERR_W-1:0] n_err;
    logic signed [SUM_W-1:0] n_sum;
    logic signed [DER_W-1:0] n_der;
    logic signed [DER_W-1:0] err_x;
    logic signed [DER_W-1:0] ep_x;
    logic signed [DER_W-1:0] ep2_x;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    assign n_err = {i_setpoint[DATA_WIDTH-1], i_setpoint}
                 - {i_measurement[DATA_WIDTH-1], i_measurement};
    assign n_sum = {n_err[ERR_W-1], n_err} + {r_ep[ERR_W-1], r_ep};

    // three-point backward difference: 3e - 4e[-1] + e[-2]
    assign err_x = {{3{n_err[ERR_W-1]}}, n_err};
    assign ep_x  = {{3{r_ep[ERR_W-1]}}, r_ep};
    assign ep2_x = {{3{r_ep2[ERR_W-1]}}, r_ep2};
    assign n_der = (err_x <<< 1) + err_x - (ep_x <<< 2) + ep2_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_ep    <= '0;
            r_ep2   <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                if (i_clear) begin
                    r_ep  <= '0;
                    r_ep2 <= '0;
                end else begin
                    r_ep  <= n_err;
                    r_ep2 <= r_ep;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_clear <= i_clear;
            r_err   <= i_clear ? '0 : n_err;
            r_sum   <= i_clear ? '0 : n_sum;
            r_der   <= i_clear ? '0 : n_der;
        end
    end

    assign o_valid   = r_valid;
    assign o_err     = r_err;
    assign o_err_sum = r_sum;
    assign o_err_der = r_der;
    assign o_clear   = r_clear;

    `PID_ASSERT_NXT(a_clear_history, i_clk, i_rst_n, load && i_clear, r_ep == '0 && r_ep2 == '0)

endmodule

`default_nettype wire

// File: rtl/pidtrap_mul.sv
// pidtrap_mul: gain multiply stage for the P, I-step and D terms plus the zero-band compare
// depends on pidtrap_pkg
`default_nettype none

module pidtrap_mul
    import pidtrap_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    localparam int ERR_W = DATA_WIDTH + 1,
    localparam int SUM_W = DATA_WIDTH + 2,
    localparam int DER_W = DATA_WIDTH + 4,
    localparam int P_W   = GAIN_W + 1 + ERR_W,
    localparam int I_W   = GAIN_W + 1 + SUM_W,
    localparam int D_W   = GAIN_W + 1 + DER_W,
    localparam int CMP_W = (ERR_W > BAND_W) ? ERR_W : BAND_W
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_gain_cfg               i_cfg,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic signed [ERR_W-1:0] i_err,
    input  logic signed [SUM_W-1:0] i_err_sum,
    input  logic signed [DER_W-1:0] i_err_der,
    input  logic                    i_clear,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic signed [P_W-1:0]   o_p,
    output logic signed [I_W-1:0]   o_step,
    output logic signed [D_W-1:0]   o_d,
    output logic                    o_band,
    output logic                    o_clear
);

    logic                  r_valid;
    logic signed [P_W-1:0] r_p;
    logic signed [I_W-1:0] r_step;
    logic signed [D_W-1:0] r_d;
    logic                  r_band;
    logic                  r_clear;

    logic                  load;
    logic signed [P_W-1:0] n_p;
    logic signed [I_W-1:0] n_step;
    logic signed [D_W-1:0] n_d;
    logic [ERR_W-1:0]      err_abs;
    logic                  n_band;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    assign n_p    = $signed({1'b0, i_cfg.prop_gain}) * i_err;
    assign n_step = $signed({1'b0, i_cfg.integ_gain}) * i_err_sum;
    assign n_d    = $signed({1'b0, i_cfg.deriv_gain}) * i_err_der;

    // the error never reaches the most negative code, so negation is safe
    assign err_abs = i_err[ERR_W-1] ? ERR_W'(-i_err) : ERR_W'(i_err);
    assign n_band  = CMP_W'(err_abs) < CMP_W'(i_cfg.zero_band);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_p     <= n_p;
            r_step  <= n_step;
            r_d     <= n_d;
            r_band  <= n_band;
            r_clear <= i_clear;
        end
    end

    assign o_valid = r_valid;
    assign o_p     = r_p;
    assign o_step  = r_step;
    assign o_d     = r_d;
    assign o_band  = r_band;
    assign o_clear = r_clear;

endmodule

`default_nettype wire

// File: rtl/pidtrap_integ.sv
// pidtrap_integ: integral accumulator with anti-windup clamp and zero-band clear,
// also adds the P and D terms; depends on pidtrap_pkg
`default_nettype none
`include "pid_controller_trapezoid_integral_defines.svh"

module pidtrap_integ
    import pidtrap_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    localparam int P_W   = GAIN_W + DATA_WIDTH + 2,
    localparam int I_W   = GAIN_W + DATA_WIDTH + 3,
    localparam int D_W   = GAIN_W + DATA_WIDTH + 5,
    localparam int PD_W  = D_W + 1,
    localparam int NEW_W = ((ACC_BITS > I_W) ? ACC_BITS : I_W) + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [LIMIT_W-1:0]         i_integ_limit,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic signed [P_W-1:0]      i_p,
    input  logic signed [I_W-1:0]      i_step,
    input  logic signed [D_W-1:0]      i_d,
    input  logic                       i_band,
    input  logic                       i_clear,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic signed [PD_W-1:0]     o_pd,
    output logic signed [ACC_BITS-1:0] o_ival,
    output logic                       o_clear
);

    logic                       r_valid;
    logic signed [ACC_BITS-1:0] r_acc;
    logic signed [PD_W-1:0]     r_pd;
    logic signed [ACC_BITS-1:0] r_ival;
    logic                       r_clear;

    logic                       load;
    logic signed [NEW_W-1:0]    acc_sum;
    logic signed [NEW_W-1:0]    lim;
    logic signed [NEW_W-1:0]    acc_max;
    logic signed [NEW_W-1:0]    hi;
    logic signed [NEW_W-1:0]    lo;
    logic signed [NEW_W-1:0]    clamped;
    logic signed [ACC_BITS-1:0] n_acc;
    logic signed [PD_W-1:0]     n_pd;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    assign acc_sum = NEW_W'(r_acc) + NEW_W'(i_step);
    assign lim     = $signed(NEW_W'({i_integ_limit, {FRAC_BITS{1'b0}}}));
    assign acc_max = $signed(NEW_W'({1'b0, {(ACC_BITS-1){1'b1}}}));

    // a zero limit falls back to the accumulator's own range
    assign hi = (i_integ_limit != '0) ? lim : acc_max;
    assign lo = (i_integ_limit != '0) ? -lim : -acc_max - NEW_W'(1);

    always_comb begin
        if (acc_sum > hi) begin
            clamped = hi;
        end else if (acc_sum < lo) begin
            clamped = lo;
        end else begin
            clamped = acc_sum;
        end
    end

    assign n_acc = (i_clear || i_band) ? '0 : clamped[ACC_BITS-1:0];
    assign n_pd  = PD_W'(i_p) + PD_W'(i_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_acc <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_pd    <= n_pd;
            r_ival  <= n_acc;
            r_clear <= i_clear;
        end
    end

    assign o_valid = r_valid;
    assign o_pd    = r_pd;
    assign o_ival  = r_ival;
    assign o_clear = r_clear;

    `PID_ASSERT_NXT(a_acc_zeroed, i_clk, i_rst_n, load && (i_clear || i_band), r_acc == '0)

endmodule

`default_nettype wire

// File: rtl/pidtrap_out.sv
// pidtrap_out: sums P+D with the integral, drops the fraction bits, saturates to the
// output limits (zero on clear) and holds the result word; depends on pidtrap_pkg
`default_nettype none
`include "pid_controller_trapezoid_integral_defines.svh"

module pidtrap_out
    import pidtrap_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    localparam int PD_W  = GAIN_W + DATA_WIDTH + 6,
    localparam int SUM_W = ((PD_W > ACC_BITS) ? PD_W : ACC_BITS) + 1,
    localparam int Y_W   = SUM_W - FRAC_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic signed [DATA_WIDTH-1:0] i_out_min,
    input  logic signed [DATA_WIDTH-1:0] i_out_max,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [PD_W-1:0]       i_pd,
    input  logic signed [ACC_BITS-1:0]   i_ival,
    input  logic                         i_clear,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [DATA_WIDTH-1:0]        o_control_out,
    output logic                         o_clipped
);

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_y;
    logic                  r_clip;

    logic                  load;
    logic signed [SUM_W-1:0] sum;
    logic signed [Y_W-1:0] y;
    logic signed [Y_W-1:0] y_max;
    logic signed [Y_W-1:0] y_min;
    logic [DATA_WIDTH-1:0] n_y;
    logic                  n_clip;

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    assign sum   = SUM_W'(i_pd) + SUM_W'(i_ival);
    // dropping the low bits is a floor shift
    assign y     = sum[SUM_W-1:FRAC_BITS];
    assign y_max = Y_W'(i_out_max);
    assign y_min = Y_W'(i_out_min);

    // upper limit checked first: with crossed limits y above out_max gets out_max
    always_comb begin
        n_y    = y[DATA_WIDTH-1:0];
        n_clip = 1'b0;
        if (i_clear) begin
            n_y = '0;
        end else if (y > y_max) begin
            n_y    = i_out_max;
            n_clip = 1'b1;
        end else if (y < y_min) begin
            n_y    = i_out_min;
            n_clip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_y    <= n_y;
            r_clip <= n_clip;
        end
    end

    assign o_valid       = r_valid;
    assign o_control_out = r_y;
    assign o_clipped     = r_clip;

    `PID_ASSERT_IMP(a_clip_at_limit, i_clk, i_rst_n, r_valid && r_clip, r_y == i_out_max || r_y == i_out_min)
    `PID_ASSERT_NXT(a_clear_output, i_clk, i_rst_n, load && i_clear, r_y == '0 && !r_clip)

endmodule

`default_nettype wire

// File: rtl/pid_controller_trapezoid_integral.sv
// pid_controller_trapezoid_integral: top level, configuration registers and the
// four-stage pid pipeline; depends on pidtrap_pkg and the pidtrap_* stage modules
//
// usage:
//   s_axis carries one sample word per transfer: tdata holds setpoint and measurement,
//   tuser the clear flag. m_axis returns one word per sample: control_out in tdata,
//   the clipped flag in tuser. the cfg channel writes gains and limits by index
//   (0 prop_gain .. 6 zero_band, higher indexes ignored); it is always ready and
//   should only be used while no sample is in flight.
//   pipeline: four register stages; a sample is registered in the front, mul, integ and
//   out stages in that order before its result word shows on m_axis.
//   throughput: one sample per cycle unless m_axis stalls; the integral accumulator
//   is updated by one combinational add and clamp, so a new sample can follow every clock.
//   each stage holds its own valid bit and loads whenever the stage after it is empty
//   or moving, so s_axis keeps taking words while a result waits on m_axis until all
//   four stages are full. with m_axis_tready low and the pipe full, s_axis_tready drops.
//   reset clears the pipeline, the error history and the integral, and loads the
//   default gains (unity proportional gain) and full-range output limits.
`default_nettype none

module pid_controller_trapezoid_integral
    import pidtrap_pkg::*;
#(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH,
    parameter int FRAC_BITS  = DEF_FRAC_BITS,
    localparam int IN_TDATA_W  = ((2 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int CFG_W       = (DATA_WIDTH > GAIN_W) ? DATA_WIDTH : GAIN_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // setpoint, measurement
    input  logic [0:0]             s_axis_tuser,   // clear
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // control_out
    output logic [0:0]             m_axis_tuser,   // clipped
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [REG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data
);

    localparam int ERR_W = DATA_WIDTH + 1;
    localparam int SUM_W = DATA_WIDTH + 2;
    localparam int DER_W = DATA_WIDTH + 4;
    localparam int P_W   = GAIN_W + 1 + ERR_W;
    localparam int I_W   = GAIN_W + 1 + SUM_W;
    localparam int D_W   = GAIN_W + 1 + DER_W;
    localparam int PD_W  = D_W + 1;

    t_gain_cfg                    r_cfg;
    logic signed [DATA_WIDTH-1:0] r_out_min;
    logic signed [DATA_WIDTH-1:0] r_out_max;

    logic                    fr_valid;
    logic                    fr_ready;
    logic signed [ERR_W-1:0] fr_err;
    logic signed [SUM_W-1:0] fr_sum;
    logic signed [DER_W-1:0] fr_der;
    logic                    fr_clear;

    logic                    mu_valid;
    logic                    mu_ready;
    logic signed [P_W-1:0]   mu_p;
    logic signed [I_W-1:0]   mu_step;
    logic signed [D_W-1:0]   mu_d;
    logic                    mu_band;
    logic                    mu_clear;

    logic                       in_valid;
    logic                       in_ready;
    logic signed [PD_W-1:0]     in_pd;
    logic signed [ACC_BITS-1:0] in_ival;
    logic                       in_clear;

    logic [DATA_WIDTH-1:0] control_out;
    logic                  clipped;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain   <= PROP_GAIN_RST;
            r_cfg.integ_gain  <= '0;
            r_cfg.deriv_gain  <= '0;
            r_cfg.integ_limit <= '0;
            r_cfg.zero_band   <= ZERO_BAND_RST;
            r_out_min         <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
            r_out_max         <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_PROP_GAIN:   r_cfg.prop_gain   <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG_GAIN:  r_cfg.integ_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:  r_cfg.deriv_gain  <= i_cfg_data[GAIN_W-1:0];
                REG_INTEG_LIMIT: r_cfg.integ_limit <= i_cfg_data[LIMIT_W-1:0];
                REG_OUT_MIN:     r_out_min         <= i_cfg_data[DATA_WIDTH-1:0];
                REG_OUT_MAX:     r_out_max         <= i_cfg_data[DATA_WIDTH-1:0];
                REG_ZERO_BAND:   r_cfg.zero_band   <= i_cfg_data[BAND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pidtrap_front #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_setpoint   ($signed(s_axis_tdata[DATA_WIDTH-1:0])),
        .i_measurement($signed(s_axis_tdata[2*DATA_WIDTH-1:DATA_WIDTH])),
        .i_clear      (s_axis_tuser[0]),
        .o_valid      (fr_valid),
        .i_ready      (fr_ready),
        .o_err        (fr_err),
        .o_err_sum    (fr_sum),
        .o_err_der    (fr_der),
        .o_clear      (fr_clear)
    );

    pidtrap_mul #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (fr_valid),
        .o_ready  (fr_ready),
        .i_err    (fr_err),
        .i_err_sum(fr_sum),
        .i_err_der(fr_der),
        .i_clear  (fr_clear),
        .o_valid  (mu_valid),
        .i_ready  (mu_ready),
        .o_p      (mu_p),
        .o_step   (mu_step),
        .o_d      (mu_d),
        .o_band   (mu_band),
        .o_clear  (mu_clear)
    );

    pidtrap_integ #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_integ (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_integ_limit(r_cfg.integ_limit),
        .i_valid      (mu_valid),
        .o_ready      (mu_ready),
        .i_p          (mu_p),
        .i_step       (mu_step),
        .i_d          (mu_d),
        .i_band       (mu_band),
        .i_clear      (mu_clear),
        .o_valid      (in_valid),
        .i_ready      (in_ready),
        .o_pd         (in_pd),
        .o_ival       (in_ival),
        .o_clear      (in_clear)
    );

    pidtrap_out #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_out_min    (r_out_min),
        .i_out_max    (r_out_max),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_pd         (in_pd),
        .i_ival       (in_ival),
        .i_clear      (in_clear),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_control_out(control_out),
        .o_clipped    (clipped)
    );

    assign m_axis_tdata = OUT_TDATA_W'(control_out);
    assign m_axis_tuser = clipped;

endmodule

`default_nettype wire
